/* hdl/ddnmm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddnmm_pkg: shared types and constants for the date day-number block
// Item structs, calendar tables and the constants of the group tracker.
// ----------------------------------------------------------------------------
package ddnmm_pkg;

    // Number of valid dates in one tracking group (1 to 8).
    localparam int GROUP_SIZE = 6;

    // Depth of the queue between the front and the back part.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [13:0] YEAR_MAX      = 14'd9999;
    localparam logic [3:0]  MONTH_FEB     = 4'd2;
    localparam logic [3:0]  MONTH_MAX     = 4'd12;
    localparam logic [4:0]  LEAP_FEB_DAYS = 5'd29;
    localparam logic [8:0]  DAYS_PER_YEAR = 9'd365;
    localparam logic [6:0]  CENTURY       = 7'd100;

    // floor(v / 100) == (v * RECIP_100) >> RECIP_SHIFT for every 14-bit v.
    localparam logic [12:0] RECIP_100   = 13'd5243;
    localparam int          RECIP_SHIFT = 19;

    typedef struct packed {
        logic [5:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
    } ddnmm_in_t;

    typedef struct packed {
        logic        valid_res;
        logic [21:0] day_number;
        logic [2:0]  oldest_position;
        logic [2:0]  youngest_position;
        logic        group_done;
    } ddnmm_out_t;

    // A classified date as it travels from the front to the back part.
    typedef struct packed {
        logic        ok;
        logic [21:0] day_number;
    } ddnmm_item_t;

    // Days in each month of a common year; zero for codes that are no month.
    function automatic logic [4:0] month_len(input logic [3:0] m);
        logic [4:0] len;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    // Days before the first of each month in a common year.
    function automatic logic [8:0] month_start(input logic [3:0] m);
        logic [8:0] start;
        unique case (m)
            4'd2:    start = 9'd31;
            4'd3:    start = 9'd59;
            4'd4:    start = 9'd90;
            4'd5:    start = 9'd120;
            4'd6:    start = 9'd151;
            4'd7:    start = 9'd181;
            4'd8:    start = 9'd212;
            4'd9:    start = 9'd243;
            4'd10:   start = 9'd273;
            4'd11:   start = 9'd304;
            4'd12:   start = 9'd334;
            default: start = 9'd0;
        endcase
        return start;
    endfunction

endpackage

/* hdl/ddnmm_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddnmm_front: date check and day-number pipeline
// Three stages validate each date and compute its day number in closed form.
// ----------------------------------------------------------------------------
module ddnmm_front (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  ddnmm_pkg::ddnmm_in_t    s_data,
    input  logic                    q_full,
    output logic                    q_push,
    output ddnmm_pkg::ddnmm_item_t  q_data
);
    import ddnmm_pkg::*;

    // The whole pipeline holds when its last stage cannot hand off.
    logic advance;

    // Stage 1: range checks and the year quotient by 100.
    logic        v1_reg, v1_next;
    logic        pre_ok_reg;
    logic [5:0]  d1_reg;
    logic [3:0]  m1_reg;
    logic [13:0] y1_reg;
    logic [7:0]  qy1_reg;
    logic [26:0] prod;
    logic        pre_ok;

    // Stage 2: leap year, month length, split of the day count.
    logic        v2_reg, v2_next;
    logic        ok2_reg;
    logic [13:0] p2_reg;
    logic [7:0]  q100_2_reg;
    logic [5:0]  q400_2_reg;
    logic [8:0]  moff2_reg;
    logic [13:0] rem_full;
    logic [6:0]  rem;
    logic        leap;
    logic [4:0]  lim;
    logic [7:0]  q100p;
    logic        after_feb;

    // Stage 3: classified item ready for the queue.
    logic        v3_reg, v3_next;
    ddnmm_item_t item3_reg;
    logic [21:0] dn_sum;

    assign advance = !(v3_reg && q_full);
    assign s_ready = advance;
    assign q_push  = v3_reg && advance;
    assign q_data  = item3_reg;

    assign v1_next = advance ? s_valid : v1_reg;
    assign v2_next = advance ? v1_reg  : v2_reg;
    assign v3_next = advance ? v2_reg  : v3_reg;

    always_comb begin
        prod   = 27'(s_data.year) * 27'(RECIP_100);
        pre_ok = (s_data.year != 14'd0) && (s_data.year <= YEAR_MAX)
                 && (s_data.month != 4'd0) && (s_data.month <= MONTH_MAX)
                 && (s_data.day != 6'd0);
    end

    always_comb begin
        rem_full  = y1_reg - 14'(qy1_reg) * 14'(CENTURY);
        rem       = rem_full[6:0];
        leap      = (y1_reg[1:0] == 2'b00) && ((rem != 7'd0) || (qy1_reg[1:0] == 2'b00));
        lim       = ((m1_reg == MONTH_FEB) && leap) ? LEAP_FEB_DAYS : month_len(m1_reg);
        // floor((y-1)/100) from floor(y/100): one less when y is a whole century.
        q100p     = (rem == 7'd0) ? (qy1_reg - 8'd1) : qy1_reg;
        after_feb = (m1_reg > MONTH_FEB) && leap;
    end

    always_comb begin
        dn_sum = 22'(p2_reg) * 22'(DAYS_PER_YEAR)
                 + 22'(p2_reg[13:2])
                 - 22'(q100_2_reg)
                 + 22'(q400_2_reg)
                 + 22'(moff2_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            pre_ok_reg <= pre_ok;
            d1_reg     <= s_data.day;
            m1_reg     <= s_data.month;
            y1_reg     <= s_data.year;
            qy1_reg    <= prod[RECIP_SHIFT +: 8];

            ok2_reg    <= pre_ok_reg && (d1_reg <= 6'(lim));
            p2_reg     <= y1_reg - 14'd1;
            q100_2_reg <= q100p;
            q400_2_reg <= q100p[7:2];
            moff2_reg  <= month_start(m1_reg) + 9'(after_feb) + 9'(d1_reg);

            item3_reg.ok         <= ok2_reg;
            item3_reg.day_number <= ok2_reg ? dn_sum : 22'd0;
        end
    end

endmodule

/* hdl/ddnmm_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddnmm_queue: short item queue between front and back
// Register-based first-in first-out buffer with a fill count.
// ----------------------------------------------------------------------------
module ddnmm_queue (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    push,
    input  ddnmm_pkg::ddnmm_item_t  push_data,
    output logic                    full,
    input  logic                    pop,
    output logic                    empty,
    output ddnmm_pkg::ddnmm_item_t  pop_data
);
    import ddnmm_pkg::*;

    ddnmm_item_t          entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]    count_reg, count_next;

    assign full     = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* hdl/ddnmm_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddnmm_back: group earliest/latest tracker and result register
// Applies each classified date to the group state and holds the result item.
// ----------------------------------------------------------------------------
module ddnmm_back (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    q_empty,
    input  ddnmm_pkg::ddnmm_item_t  q_data,
    output logic                    q_pop,
    output logic                    m_valid,
    input  logic                    m_ready,
    output ddnmm_pkg::ddnmm_out_t   m_data
);
    import ddnmm_pkg::*;

    logic [2:0]  count_reg,     count_next;
    logic [21:0] early_reg,     early_next;
    logic [2:0]  early_pos_reg, early_pos_next;
    logic [21:0] late_reg,      late_next;
    logic [2:0]  late_pos_reg,  late_pos_next;
    logic        m_valid_reg,   m_valid_next;
    ddnmm_out_t  m_data_reg,    m_data_next;
    logic [3:0]  pos_plus1;
    logic        done;

    assign q_pop   = !q_empty && (!m_valid_reg || m_ready);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        count_next     = count_reg;
        early_next     = early_reg;
        early_pos_next = early_pos_reg;
        late_next      = late_reg;
        late_pos_next  = late_pos_reg;
        pos_plus1      = {1'b0, count_reg} + 4'd1;
        done           = (pos_plus1 >= 4'(GROUP_SIZE));

        if (count_reg == 3'd0) begin
            early_next     = q_data.day_number;
            early_pos_next = 3'd0;
            late_next      = q_data.day_number;
            late_pos_next  = 3'd0;
        end else begin
            if (q_data.day_number < early_reg) begin
                early_next     = q_data.day_number;
                early_pos_next = count_reg;
            end
            if (q_data.day_number > late_reg) begin
                late_next     = q_data.day_number;
                late_pos_next = count_reg;
            end
        end
        count_next = done ? 3'd0 : pos_plus1[2:0];

        // An invalid date leaves the group state alone.
        if (!q_data.ok) begin
            count_next     = count_reg;
            early_next     = early_reg;
            early_pos_next = early_pos_reg;
            late_next      = late_reg;
            late_pos_next  = late_pos_reg;
        end

        m_data_next.valid_res         = q_data.ok;
        m_data_next.day_number        = q_data.ok ? q_data.day_number : 22'd0;
        m_data_next.oldest_position   = early_pos_next;
        m_data_next.youngest_position = late_pos_next;
        m_data_next.group_done        = q_data.ok && done;

        m_valid_next = q_pop ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= 3'd0;
            early_reg     <= 22'd0;
            early_pos_reg <= 3'd0;
            late_reg      <= 22'd0;
            late_pos_reg  <= 3'd0;
            m_valid_reg   <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (q_pop) begin
                count_reg     <= count_next;
                early_reg     <= early_next;
                early_pos_reg <= early_pos_next;
                late_reg      <= late_next;
                late_pos_reg  <= late_pos_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            m_data_reg <= m_data_next;
        end
    end

endmodule

/* hdl/date_day_number_min_max.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// date_day_number_min_max: Gregorian date check, day number, group min/max
// Top level joining the classify pipeline, the item queue and the tracker.
// ----------------------------------------------------------------------------
// Each input item is one Gregorian date (day, month, year). The block checks
// it (year 1 to 9999, month 1 to 12, day within the month, February 29 only
// in leap years) and turns a valid date into its day number, with 1 January
// of year 1 as day 1. Valid dates are counted in groups of GROUP_SIZE; for
// each result item the block reports the positions of the earliest and the
// latest date of the current group so far, the first one winning a tie, and
// flags the date that closes the group. An invalid date yields a result item
// with valid_res low, a zero day number and the stored positions, and it does
// not count toward the group. The block takes one item per clock cycle while
// its input is not stalled and gives one result item per input item, in order.
// After its item is accepted, a result item passes through the three pipeline
// stages of the front part (range check with the year quotient by 100,
// leap-year and month work, final day-count sum), then the queue, and then
// the output register of the tracker. The four-entry queue lets the front
// keep accepting while the result side is stalled; the input stalls only once
// that queue is full and the front pipeline's last stage is holding an item.
// ----------------------------------------------------------------------------
module date_day_number_min_max (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  ddnmm_pkg::ddnmm_in_t    s_data,
    output logic                    m_valid,
    input  logic                    m_ready,
    output ddnmm_pkg::ddnmm_out_t   m_data
);
    import ddnmm_pkg::*;

    // Front-to-queue and queue-to-back connections.
    logic        q_push;
    logic        q_full;
    ddnmm_item_t q_push_data;
    logic        q_pop;
    logic        q_empty;
    ddnmm_item_t q_pop_data;

    // The front validates each date and computes its day number.
    ddnmm_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_data  (q_push_data)
    );

    // The queue decouples the front pipeline from result back-pressure.
    ddnmm_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .pop_data  (q_pop_data)
    );

    // The back applies each date to the group state and holds the result.
    ddnmm_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_empty (q_empty),
        .q_data  (q_pop_data),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

`ifndef SYNTHESIS
    // The front never writes into a full queue.
    assert property (@(posedge aclk) disable iff (!aresetn) q_push |-> !q_full)
        else $error("item pushed into a full queue");

    // The back never reads from an empty queue.
    assert property (@(posedge aclk) disable iff (!aresetn) q_pop |-> !q_empty)
        else $error("item popped from an empty queue");

    // Only a valid date can close a group, and an invalid one carries day zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.valid_res) |-> (!m_data.group_done && m_data.day_number == 22'd0))
        else $error("invalid date result carries group or day data");

    // Reported positions always lie inside the group.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (32'(m_data.oldest_position) < GROUP_SIZE
                     && 32'(m_data.youngest_position) < GROUP_SIZE))
        else $error("group position out of range");
`endif

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the Gregorian date day-number block
// Sends directed and random dates, predicts every result item locally and
// checks them in order, with random gaps on both channels and one long stall.
// ----------------------------------------------------------------------------
module tb;
    import ddnmm_pkg::*;

    localparam int RANDOM_ITEMS = 1880;
    localparam int DRAIN_CYCLES = 20;

    // Days per month in a common year, index 0 unused.
    localparam int COMMON_MONTH_DAYS [13] = '{0, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    logic       aclk    = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    ddnmm_in_t  s_data  = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    ddnmm_out_t m_data;

    date_day_number_min_max u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Dates waiting to be offered, and the result items they are predicted to give.
    ddnmm_in_t  pending_dates [$];
    ddnmm_out_t expected_results [$];

    int accepted_total = 0;
    int item_total     = 0;
    int mismatch_count = 0;
    logic hold_off     = 1'b0;

    // The tracker as the bench sees it: fill level of the current group and
    // the earliest and latest day numbers with their positions.
    logic [2:0]  group_fill   = '0;
    logic [21:0] earliest_day = '0;
    logic [2:0]  earliest_pos = '0;
    logic [21:0] latest_day   = '0;
    logic [2:0]  latest_pos   = '0;

    function automatic bit is_leap(int year);
        return ((year % 4) == 0 && (year % 100) != 0) || (year % 400) == 0;
    endfunction

    // Length of a month; zero for a code that names no month.
    function automatic int month_days(int month, int year);
        if (month < 1 || month > 12) return 0;
        if (month == 2 && is_leap(year)) return 29;
        return COMMON_MONTH_DAYS[month];
    endfunction

    // Predicts the result item of one accepted date and advances the tracker.
    function automatic ddnmm_out_t track_date(ddnmm_in_t date);
        ddnmm_out_t res;
        int day, month, year, prior, days;
        day   = date.day;
        month = date.month;
        year  = date.year;
        res   = '0;
        if (year < 1 || year > int'(YEAR_MAX) || day < 1 || day > month_days(month, year)) begin
            // An invalid date leaves the tracker untouched and repeats its positions.
            res.oldest_position   = earliest_pos;
            res.youngest_position = latest_pos;
            return res;
        end
        prior = year - 1;
        days  = 365 * prior + prior / 4 - prior / 100 + prior / 400 + day;
        for (int k = 1; k < month; k++) begin
            days += COMMON_MONTH_DAYS[k];
        end
        if (month > 2 && is_leap(year)) days += 1;

        if (group_fill == 0) begin
            earliest_day = 22'(days);
            earliest_pos = 3'd0;
            latest_day   = 22'(days);
            latest_pos   = 3'd0;
        end else begin
            // Strict compares, so the first of equal dates keeps its position.
            if (days < earliest_day) begin
                earliest_day = 22'(days);
                earliest_pos = group_fill;
            end
            if (days > latest_day) begin
                latest_day = 22'(days);
                latest_pos = group_fill;
            end
        end
        res.valid_res         = 1'b1;
        res.day_number        = 22'(days);
        res.oldest_position   = earliest_pos;
        res.youngest_position = latest_pos;
        res.group_done        = (int'(group_fill) + 1 >= GROUP_SIZE);
        group_fill = res.group_done ? 3'd0 : group_fill + 3'd1;
        return res;
    endfunction

    task automatic add_date(int day, int month, int year);
        ddnmm_in_t date;
        date.day   = 6'(day);
        date.month = 4'(month);
        date.year  = 14'(year);
        pending_dates.push_back(date);
    endtask

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return 0;
        if (r < 97) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Random dates: mostly well-formed ones with a bias toward leap-year
    // boundaries, month ends, the year extremes and repeated dates (ties),
    // then near misses and fully random field values.
    task automatic add_random_dates(int count);
        int day, month, year, len, r;
        int last_day = 1, last_month = 1, last_year = 1;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                if ($urandom_range(0, 9) == 0) begin
                    day   = last_day;
                    month = last_month;
                    year  = last_year;
                end else begin
                    case ($urandom_range(0, 9))
                        0:       year = $urandom_range(1, 3);
                        1:       year = $urandom_range(9997, 9999);
                        2, 3:    year = 100 * $urandom_range(1, 99);
                        default: year = $urandom_range(1, 9999);
                    endcase
                    month = ($urandom_range(0, 5) == 0) ? 2 : $urandom_range(1, 12);
                    len   = month_days(month, year);
                    day   = ($urandom_range(0, 3) == 0) ? len : $urandom_range(1, len);
                end
                last_day   = day;
                last_month = month;
                last_year  = year;
            end else if (r < 82) begin
                year  = $urandom_range(1, 9999);
                month = $urandom_range(1, 12);
                day   = month_days(month, year) + 1;
                case ($urandom_range(0, 3))
                    0: year  = 0;
                    1: month = ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(13, 15);
                    2: day   = 0;
                    default: ;
                endcase
            end else begin
                day   = $urandom_range(0, 63);
                month = $urandom_range(0, 15);
                year  = $urandom_range(0, 16383);
            end
            add_date(day, month, year);
        end
    endtask

    // Sender: offers the pending dates with random gaps and predicts each
    // result item at the edge where its date is accepted.
    int send_gap   = 0;
    int send_burst = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_results.push_back(track_date(s_data));
                accepted_total++;
            end
            if (!s_valid || s_ready) begin
                if (send_gap != 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (pending_dates.size() != 0) begin
                    s_valid <= 1'b1;
                    s_data  <= pending_dates.pop_front();
                    if (send_burst != 0) begin
                        send_burst--;
                    end else begin
                        send_gap = pick_gap();
                        if ($urandom_range(0, 49) == 0) send_burst = $urandom_range(20, 80);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each accepted result item against the oldest prediction
    // and drops ready at random, or for the whole of the long hold-off.
    int recv_gap   = 0;
    int recv_burst = 0;

    always @(posedge aclk) begin
        ddnmm_out_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: result item with nothing expected: %p", $realtime, m_data);
                end else begin
                    want = expected_results.pop_front();
                    if (m_data.valid_res !== want.valid_res
                        || m_data.day_number !== want.day_number
                        || m_data.oldest_position !== want.oldest_position
                        || m_data.youngest_position !== want.youngest_position
                        || m_data.group_done !== want.group_done) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("%0t: mismatch expected %p actual %p", $realtime, want, m_data);
                    end
                end
            end
            if (hold_off) begin
                m_ready <= 1'b0;
            end else if (recv_gap != 0) begin
                recv_gap--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (recv_burst != 0) begin
                    recv_burst--;
                end else begin
                    recv_gap = pick_gap();
                    if ($urandom_range(0, 49) == 0) recv_burst = $urandom_range(20, 80);
                end
            end
        end
    end

    // Long receiver stall partway through, so the queue inside the block fills
    // and the input side has to stall while the sender keeps offering dates.
    initial begin
        wait (accepted_total >= 400);
        @(posedge aclk);
        hold_off <= 1'b1;
        repeat (300) @(posedge aclk);
        hold_off <= 1'b0;
    end

    initial begin
        // Directed dates: day number extremes, leap-year rules (divisible by
        // four, century years, years divisible by 400), days on either side
        // of some month ends, every kind of invalid field, and repeated dates
        // to show that a tie keeps the first position.
        add_date(1, 1, 1);
        add_date(31, 12, 9999);
        add_date(29, 2, 2000);
        add_date(29, 2, 1900);
        add_date(28, 2, 1900);
        add_date(29, 2, 2024);
        add_date(29, 2, 2023);
        add_date(1, 3, 2000);
        add_date(1, 3, 1900);
        add_date(0, 1, 2020);
        add_date(63, 1, 2020);
        add_date(32, 1, 2020);
        add_date(31, 4, 2020);
        add_date(30, 4, 2020);
        add_date(1, 0, 2020);
        add_date(1, 13, 2020);
        add_date(1, 15, 2020);
        add_date(1, 1, 0);
        add_date(1, 1, 10000);
        add_date(63, 15, 16383);
        add_date(15, 6, 1500);
        add_date(15, 6, 1500);
        add_date(15, 6, 1500);
        add_date(31, 12, 9999);
        add_random_dates(RANDOM_ITEMS);
        item_total = pending_dates.size();

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Every date accepted and every prediction checked, then the drain
        // wait in case the block sends anything it should not.
        while (accepted_total < item_total) @(posedge aclk);
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Far above the slowest correct run of this stimulus.
    initial begin
        #10_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
